FILE: sv/khrt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and function codes of the key hold and repeat tracker.
// No dependencies; every other file imports this package.
package khrt_pkg;

  localparam int NUM_KEYS  = 256;
  localparam int KEY_BITS  = 8;
  localparam int TIME_BITS = 32;
  localparam int FRAC_BITS = 8;
  localparam int MULT_BITS = 14;
  localparam int FLAG_BITS = 7;
  localparam int ADDR_BITS = 4;

  localparam logic [MULT_BITS-1:0] MULT_ONE = MULT_BITS'(1 << FRAC_BITS);

  // Reset values of the configuration registers
  localparam logic [TIME_BITS-1:0] HOLD_TIME_RST     = TIME_BITS'(900);
  localparam logic [TIME_BITS-1:0] REPEAT_PERIOD_RST = TIME_BITS'(850);
  localparam logic [MULT_BITS-1:0] MULT_CAP_RST      = MULT_BITS'(12800);

  // Register indexes (byte address divided by four)
  localparam logic [1:0] REG_HOLD_TIME     = 2'd0;
  localparam logic [1:0] REG_REPEAT_PERIOD = 2'd1;
  localparam logic [1:0] REG_MULT_CAP      = 2'd2;

  // Function codes
  localparam logic [3:0] FN_PRESS   = 4'd0;
  localparam logic [3:0] FN_RELEASE = 4'd1;
  localparam logic [3:0] FN_LIVE    = 4'd2;
  localparam logic [3:0] FN_DOWN    = 4'd3;
  localparam logic [3:0] FN_UP      = 4'd4;
  localparam logic [3:0] FN_HELD    = 4'd5;
  localparam logic [3:0] FN_ONCE    = 4'd6;
  localparam logic [3:0] FN_REPEAT  = 4'd7;
  localparam logic [3:0] FN_MULT    = 4'd8;
  localparam logic [3:0] FN_DISARM  = 4'd9;

  // Bit positions in the per-key flag vector
  localparam int F_TRACKED = 0;
  localparam int F_PRESSED = 1;
  localparam int F_DOWN    = 2;
  localparam int F_UP      = 3;
  localparam int F_HELD    = 4;
  localparam int F_ONCE    = 5;
  localparam int F_REP     = 6;

  typedef struct packed {
    logic [3:0]           func;
    logic [KEY_BITS-1:0]  key;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] hold_override;
    logic                 live_pressed;
  } in_word_t;

  typedef struct packed {
    logic                 flag;
    logic [MULT_BITS-1:0] mult;
  } out_word_t;

  typedef struct packed {
    logic [FLAG_BITS-1:0] flags;
    logic [MULT_BITS-1:0] mult;
    logic [TIME_BITS-1:0] press_time;
    logic [TIME_BITS-1:0] repeat_time;
  } entry_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] hold_time;
    logic [TIME_BITS-1:0] repeat_period;
    logic [MULT_BITS-1:0] mult_cap;
  } cfg_t;

endpackage

FILE: sv/khrt_update.sv
`timescale 1ns / 1ps
// Per-word update of one key table entry: flags, timers and repeat multiplier.
// Depends on khrt_pkg.
module khrt_update (
  input  khrt_pkg::in_word_t  item,
  input  khrt_pkg::entry_t    cur,
  input  khrt_pkg::cfg_t      cfg,
  output khrt_pkg::entry_t    nxt,
  output khrt_pkg::out_word_t res
);
  import khrt_pkg::*;

  logic [TIME_BITS-1:0]   thr;
  logic [TIME_BITS-1:0]   press_el;
  logic [TIME_BITS-1:0]   rep_el;
  logic [MULT_BITS:0]     grown;
  logic [MULT_BITS-1:0]   capped;
  logic                   starts;
  logic                   flag;
  entry_t                 e;

  assign thr      = (item.hold_override != '0) ? item.hold_override : cfg.hold_time;
  assign press_el = TIME_BITS'(item.now - cur.press_time);
  assign rep_el   = TIME_BITS'(item.now - cur.repeat_time);
  // x + x/2, one extra bit before saturation
  assign grown    = {1'b0, cur.mult} + {2'b0, cur.mult[MULT_BITS-1:1]};
  assign capped   = (grown > {1'b0, cfg.mult_cap}) ? cfg.mult_cap : grown[MULT_BITS-1:0];
  assign starts   = (item.func >= FN_LIVE) && (item.func <= FN_REPEAT);

  always_comb begin
    e    = cur;
    flag = 1'b0;
    if (starts && !e.flags[F_TRACKED]) begin
      e.flags[F_TRACKED] = 1'b1;
      e.flags[F_PRESSED] = item.live_pressed;
    end
    case (item.func)
      FN_PRESS: begin
        if (e.flags[F_TRACKED]) begin
          e.flags[F_PRESSED] = 1'b1;
          e.flags[F_DOWN]    = 1'b1;
          e.flags[F_HELD]    = 1'b1;
          e.flags[F_ONCE]    = 1'b1;
          e.flags[F_REP]     = 1'b1;
          e.press_time       = item.now;
          e.repeat_time      = item.now;
          e.mult             = MULT_ONE;
        end
      end
      FN_RELEASE: begin
        if (e.flags[F_TRACKED]) begin
          e.flags[F_PRESSED] = 1'b0;
          e.flags[F_HELD]    = 1'b0;
          e.flags[F_ONCE]    = 1'b0;
          e.flags[F_REP]     = 1'b0;
          e.flags[F_UP]      = 1'b1;
          e.mult             = MULT_ONE;
        end
      end
      FN_LIVE: begin
        flag = item.live_pressed;
      end
      FN_DOWN: begin
        flag            = e.flags[F_DOWN];
        e.flags[F_DOWN] = 1'b0;
      end
      FN_UP: begin
        flag          = e.flags[F_UP];
        e.flags[F_UP] = 1'b0;
      end
      FN_HELD: begin
        flag = e.flags[F_PRESSED] && e.flags[F_HELD] && (press_el > thr);
      end
      FN_ONCE: begin
        if (e.flags[F_PRESSED] && e.flags[F_ONCE] && (press_el > thr)) begin
          e.flags[F_ONCE] = 1'b0;
          flag            = 1'b1;
        end
      end
      FN_REPEAT: begin
        if (!e.flags[F_PRESSED]) begin
          e.mult = MULT_ONE;
        end else if (e.flags[F_REP] && (rep_el > cfg.repeat_period)) begin
          e.mult        = capped;
          e.repeat_time = item.now;
          flag          = 1'b1;
        end
      end
      FN_DISARM: begin
        e.flags[F_HELD] = 1'b0;
        e.flags[F_ONCE] = 1'b0;
        e.flags[F_REP]  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign nxt      = e;
  assign res.flag = flag;
  assign res.mult = e.mult;

endmodule

FILE: sv/key_hold_repeat_tracker_top.sv
`timescale 1ns / 1ps
// Top level of the key hold and repeat tracker: key table memory, bypass,
// configuration registers and handshake. Depends on khrt_pkg and khrt_update.
//
// Takes one word per cycle while in_stall is low and returns one result word
// per input word. A word accepted at a clock edge is held in the input
// register until its result moves into the result register, which raises
// out_valid; this happens once the result register is empty or not stalled. A
// stalled result holds the input register, so at most two words are in flight
// and the input stalls only while both registers are full and out_stall is
// high. The key table is a 256-entry memory read at acceptance and written
// when the word moves into the result register; a bypass register carries the
// last written entry so that words on the same key may follow each other every
// cycle. Flag and multiplier resets use per-key valid bits, so no clearing
// pass is needed after reset. Configuration goes through an APB-style port at
// byte addresses 0 (hold_time), 4 (repeat_period) and 8 (mult_cap); write it
// only while the block is idle.
module key_hold_repeat_tracker_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  khrt_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output khrt_pkg::out_word_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [khrt_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import khrt_pkg::*;

  cfg_t                  cfg_r;
  entry_t                mem [NUM_KEYS];
  entry_t                rd_r;
  entry_t                byp_data_r;
  logic [KEY_BITS-1:0]   byp_key_r;
  logic                  byp_vld_r;
  logic [NUM_KEYS-1:0]   vld_r;
  in_word_t              s1_r;
  logic                  s1_vld_r;
  out_word_t             out_r;
  logic                  out_vld_r;
  entry_t                cur;
  entry_t                upd_nxt;
  out_word_t             res_nxt;
  entry_t                rst_entry;
  logic                  accept;
  logic                  advance;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_time     <= HOLD_TIME_RST;
      cfg_r.repeat_period <= REPEAT_PERIOD_RST;
      cfg_r.mult_cap      <= MULT_CAP_RST;
    end else if (cfg_wr) begin
      case (paddr[ADDR_BITS-1:2])
        REG_HOLD_TIME:     cfg_r.hold_time     <= pwdata;
        REG_REPEAT_PERIOD: cfg_r.repeat_period <= pwdata;
        REG_MULT_CAP:      cfg_r.mult_cap      <= pwdata[MULT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_BITS-1:2])
      REG_HOLD_TIME:     prdata = cfg_r.hold_time;
      REG_REPEAT_PERIOD: prdata = cfg_r.repeat_period;
      REG_MULT_CAP:      prdata = {{(32-MULT_BITS){1'b0}}, cfg_r.mult_cap};
      default:           prdata = '0;
    endcase
  end

  // Hold the input word only when the result register is full and stalled
  assign advance  = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && out_vld_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= mem[in_data.key];
    end
    if (advance) begin
      mem[s1_r.key] <= upd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      byp_vld_r <= 1'b0;
      vld_r     <= '0;
    end else begin
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (advance) begin
        s1_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r          <= 1'b1;
        byp_vld_r          <= 1'b1;
        vld_r[s1_r.key]    <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_data;
    end
    if (advance) begin
      out_r      <= res_nxt;
      byp_data_r <= upd_nxt;
      byp_key_r  <= s1_r.key;
    end
  end

  assign rst_entry.flags       = '0;
  assign rst_entry.mult        = MULT_ONE;
  assign rst_entry.press_time  = '0;
  assign rst_entry.repeat_time = '0;

  // Newest data wins: bypass, then memory, then reset value for untouched keys
  always_comb begin
    if (byp_vld_r && (byp_key_r == s1_r.key)) begin
      cur = byp_data_r;
    end else if (vld_r[s1_r.key]) begin
      cur = rd_r;
    end else begin
      cur = rst_entry;
    end
  end

  khrt_update u_update (
    .item (s1_r),
    .cur  (cur),
    .cfg  (cfg_r),
    .nxt  (upd_nxt),
    .res  (res_nxt)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_vld_r))
    else $error("input stalled with room in the pipeline");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("result register empty after advance");

  a_bypass_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (byp_vld_r && (byp_key_r == $past(s1_r.key)) && vld_r[byp_key_r]))
    else $error("bypass does not hold the last written key");

endmodule

FILE: tb/sv/tb_key_hold_repeat_tracker_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for key_hold_repeat_tracker_top: directed and random key sessions
// against an in-bench per-key table model, with random idling and one long receiver hold-off.
// Depends on khrt_pkg and the RTL of the tracker.
module tb_key_hold_repeat_tracker_top;
  import khrt_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_data;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  key_hold_repeat_tracker_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Model of the key table and registers
  logic [FLAG_BITS-1:0] key_flags [NUM_KEYS];
  logic [TIME_BITS-1:0] press_t   [NUM_KEYS];
  logic [TIME_BITS-1:0] rep_t     [NUM_KEYS];
  logic [MULT_BITS-1:0] mult_tab  [NUM_KEYS];
  logic [TIME_BITS-1:0] hold_time_m;
  logic [TIME_BITS-1:0] repeat_period_m;
  logic [MULT_BITS-1:0] mult_cap_m;

  out_word_t      pending_results [$];
  int             mismatches = 0;
  int             words_sent = 0;
  int             words_checked = 0;
  int             repeats_fired = 0;
  int             settings_used = 0;
  int             snd_idle_pct = 0;
  int             rcv_idle_pct = 0;
  int             stall_hold = 0;
  logic [31:0]    tick;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Compute the result of one word and advance the table model
  function automatic out_word_t track_key(input in_word_t w);
    logic [FLAG_BITS-1:0] f;
    logic [TIME_BITS-1:0] thr;
    logic [TIME_BITS-1:0] elapsed;
    logic [MULT_BITS:0]   grown;
    logic                 flag;
    out_word_t            r;
    f = key_flags[w.key];
    flag = 1'b0;
    if (w.func >= FN_LIVE && w.func <= FN_REPEAT && !f[F_TRACKED]) begin
      f[F_TRACKED] = 1'b1;
      f[F_PRESSED] = w.live_pressed;
    end
    thr = (w.hold_override != '0) ? w.hold_override : hold_time_m;
    case (w.func)
      FN_PRESS: begin
        if (f[F_TRACKED]) begin
          f[F_PRESSED] = 1'b1;
          f[F_DOWN] = 1'b1;
          f[F_HELD] = 1'b1;
          f[F_ONCE] = 1'b1;
          f[F_REP] = 1'b1;
          press_t[w.key] = w.now;
          rep_t[w.key] = w.now;
          mult_tab[w.key] = MULT_ONE;
        end
      end
      FN_RELEASE: begin
        if (f[F_TRACKED]) begin
          f[F_PRESSED] = 1'b0;
          f[F_HELD] = 1'b0;
          f[F_ONCE] = 1'b0;
          f[F_REP] = 1'b0;
          f[F_UP] = 1'b1;
          mult_tab[w.key] = MULT_ONE;
        end
      end
      FN_LIVE: flag = w.live_pressed;
      FN_DOWN: begin
        flag = f[F_DOWN];
        f[F_DOWN] = 1'b0;
      end
      FN_UP: begin
        flag = f[F_UP];
        f[F_UP] = 1'b0;
      end
      FN_HELD: begin
        elapsed = w.now - press_t[w.key];
        if (f[F_PRESSED] && f[F_HELD]) flag = (elapsed > thr);
      end
      FN_ONCE: begin
        elapsed = w.now - press_t[w.key];
        if (f[F_PRESSED] && f[F_ONCE] && elapsed > thr) begin
          f[F_ONCE] = 1'b0;
          flag = 1'b1;
        end
      end
      FN_REPEAT: begin
        elapsed = w.now - rep_t[w.key];
        if (!f[F_PRESSED]) begin
          mult_tab[w.key] = MULT_ONE;
        end else if (f[F_REP] && elapsed > repeat_period_m) begin
          // grow by one half, then clamp
          grown = {1'b0, mult_tab[w.key]} + {2'b0, mult_tab[w.key][MULT_BITS-1:1]};
          if (grown > {1'b0, mult_cap_m}) grown = {1'b0, mult_cap_m};
          mult_tab[w.key] = grown[MULT_BITS-1:0];
          rep_t[w.key] = w.now;
          flag = 1'b1;
          repeats_fired++;
        end
      end
      FN_DISARM: begin
        f[F_HELD] = 1'b0;
        f[F_ONCE] = 1'b0;
        f[F_REP] = 1'b0;
      end
      default: ;
    endcase
    key_flags[w.key] = f;
    r.flag = flag;
    r.mult = mult_tab[w.key];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result word with none pending", int'(got.mult), 0);
    end else begin
      want = pending_results.pop_front();
      words_checked++;
      if (got.flag !== want.flag) report_mismatch("flag", int'(got.flag), int'(want.flag));
      if (got.mult !== want.mult) report_mismatch("mult", int'(got.mult), int'(want.mult));
    end
  endtask

  // Result side: check accepted words, then pick next cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold = stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  task automatic send_word(input logic [3:0] fn, input logic [KEY_BITS-1:0] k,
                           input logic [TIME_BITS-1:0] t, input logic [TIME_BITS-1:0] ovr,
                           input logic lv);
    in_word_t w;
    int       gap;
    w.func = fn;
    w.key = k;
    w.now = t;
    w.hold_override = ovr;
    w.live_pressed = lv;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.insert(pending_results.size(), track_key(w));
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_BITS'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_HOLD_TIME:     hold_time_m = val;
      REG_REPEAT_PERIOD: repeat_period_m = val;
      REG_MULT_CAP:      mult_cap_m = val[MULT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] hold, input logic [31:0] period,
                          input logic [31:0] cap);
    wait_idle();
    write_reg(REG_HOLD_TIME, hold);
    write_reg(REG_REPEAT_PERIOD, period);
    write_reg(REG_MULT_CAP, cap);
    settings_used++;
  endtask

  // Untracked keys, first tracking, unused codes, all-ones fields
  task automatic test_tracking_rules();
    tick = 32'hFFFF_FF00;
    send_word(FN_PRESS, 8'd3, tick, '0, 1'b1);
    send_word(FN_RELEASE, 8'd3, tick, '0, 1'b0);
    send_word(FN_MULT, 8'd3, tick, '0, 1'b1);
    send_word(FN_DISARM, 8'd3, tick, '0, 1'b1);
    send_word(FN_DOWN, 8'd3, tick, '0, 1'b1);
    send_word(FN_LIVE, 8'd3, tick, '0, 1'b0);
    send_word(FN_LIVE, 8'd3, tick, '0, 1'b1);
    send_word(4'd15, 8'd3, tick, '0, 1'b0);
    send_word(FN_LIVE, 8'hFF, '1, '1, 1'b1);
    send_word(4'd10, 8'd0, '0, '0, 1'b0);
  endtask

  // Strict thresholds across the time wrap, one-shot hold, repeat and release
  task automatic test_hold_repeat_timing();
    send_word(FN_PRESS, 8'd3, tick, '0, 1'b1);
    send_word(FN_DOWN, 8'd3, tick, '0, 1'b0);
    send_word(FN_HELD, 8'd3, tick + 32'd900, '0, 1'b0);
    send_word(FN_HELD, 8'd3, tick + 32'd901, '0, 1'b0);
    send_word(FN_HELD, 8'd3, tick + 32'd901, '1, 1'b0);
    send_word(FN_HELD, 8'd3, tick + 32'd901, 32'd901, 1'b0);
    send_word(FN_ONCE, 8'd3, tick + 32'd901, '0, 1'b0);
    send_word(FN_ONCE, 8'd3, tick + 32'd950, '0, 1'b0);
    send_word(FN_REPEAT, 8'd3, tick + 32'd850, '0, 1'b0);
    send_word(FN_REPEAT, 8'd3, tick + 32'd851, '0, 1'b0);
    send_word(FN_REPEAT, 8'd3, tick + 32'd851, '0, 1'b0);
    send_word(FN_RELEASE, 8'd3, tick + 32'd900, '0, 1'b0);
    send_word(FN_UP, 8'd3, tick + 32'd900, '0, 1'b0);
    send_word(FN_REPEAT, 8'd3, tick + 32'd2000, '0, 1'b1);
  endtask

  // Hold the result side off while repeats drive the multiplier into the cap
  task automatic test_saturation_under_stall();
    set_regs(32'd0, 32'd0, 32'd16383);
    tick = $urandom();
    stall_hold = 60;
    send_word(FN_LIVE, 8'd7, tick, '0, 1'b1);
    send_word(FN_PRESS, 8'd7, tick, '0, 1'b1);
    repeat (13) begin
      tick = tick + 32'd1;
      send_word(FN_REPEAT, 8'd7, tick, '0, 1'b0);
    end
    send_word(FN_MULT, 8'd7, tick, '0, 1'b0);
  endtask

  // Key sessions with random content, mixed with arbitrary words
  task automatic test_random_phase(input int count, input logic [31:0] hold,
                                   input logic [31:0] period, input logic [31:0] cap,
                                   input int step);
    int                  stop_at;
    int                  n;
    logic [KEY_BITS-1:0] k;
    logic [3:0]          fn;
    logic [31:0]         ovr;
    set_regs(hold, period, cap);
    tick = $urandom();
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      case ($urandom_range(4))
        0:       k = 8'h00;
        1:       k = 8'hFF;
        2:       k = 8'h5A;
        3:       k = 8'hA5;
        default: k = KEY_BITS'($urandom_range(255));
      endcase
      if ($urandom_range(99) < 75) begin
        send_word($urandom_range(1) ? FN_LIVE : FN_DOWN, k, tick, '0,
                  1'($urandom_range(1)));
        send_word(FN_PRESS, k, tick, '0, 1'b1);
        n = $urandom_range(3, 8);
        repeat (n) begin
          tick = tick + $urandom_range(0, 2 * step);
          case ($urandom_range(5))
            0:       fn = FN_HELD;
            1:       fn = FN_ONCE;
            2:       fn = FN_REPEAT;
            3:       fn = FN_REPEAT;
            4:       fn = FN_DOWN;
            default: fn = FN_MULT;
          endcase
          ovr = ($urandom_range(99) < 60) ? 32'd0 : $urandom_range(1, 3 * step);
          send_word(fn, k, tick, ovr, 1'($urandom_range(1)));
        end
        if ($urandom_range(3) == 0) begin
          send_word(FN_DISARM, k, tick, '0, 1'b0);
          tick = tick + $urandom_range(0, 2 * step);
          send_word(FN_HELD, k, tick, '0, 1'b0);
        end
        tick = tick + $urandom_range(0, 2 * step);
        send_word(FN_RELEASE, k, tick, '0, 1'b0);
        send_word(FN_UP, k, tick, '0, 1'b0);
        send_word(FN_REPEAT, k, tick, '0, 1'b0);
      end else begin
        ovr = $urandom_range(1) ? $urandom() : 32'd0;
        send_word(4'($urandom_range(15)), k, $urandom_range(1) ? $urandom() : tick, ovr,
                  1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    hold_time_m = HOLD_TIME_RST;
    repeat_period_m = REPEAT_PERIOD_RST;
    mult_cap_m = MULT_CAP_RST;
    for (int i = 0; i < NUM_KEYS; i++) begin
      key_flags[i] = '0;
      press_t[i] = '0;
      rep_t[i] = '0;
      mult_tab[i] = MULT_ONE;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 18;
    rcv_idle_pct = 62;
    test_tracking_rules();
    test_hold_repeat_timing();
    test_saturation_under_stall();
    test_random_phase(72, 32'd40, 32'd30, 32'd12800, 25);
    test_random_phase(72, 32'd0, 32'd0, 32'd16383, 5);

    snd_idle_pct = 62;
    rcv_idle_pct = 18;
    test_random_phase(72, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd256, 40);
    test_random_phase(72, 32'd25, 32'd10, 32'd100, 10);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_phase(72, 32'd60, 32'd45, 32'd0, 35);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d words under %0d register settings; %0d results checked",
             words_sent, settings_used, words_checked);
    $display("Repeats fired: %0d; errors: %0d", repeats_fired, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
